// ===== rtl/jsu_pkg.sv =====
// shared types, codes and helper functions for the json string unescape block
package jsu_pkg;

	localparam int LENGTH_BITS_DEF = 16;
	localparam int MAX_RESULTS     = 6;
	localparam int IDX_W           = $clog2(MAX_RESULTS);
	localparam int CNT_W           = $clog2(MAX_RESULTS + 1);

	// input kinds
	localparam logic [1:0] IK_BEGIN = 2'd0;
	localparam logic [1:0] IK_BYTE  = 2'd1;
	localparam logic [1:0] IK_END   = 2'd2;

	// result kinds
	localparam logic [1:0] RK_DATA  = 2'd0;
	localparam logic [1:0] RK_CLOSE = 2'd1;
	localparam logic [1:0] RK_ERROR = 2'd2;

	// error codes
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_CTRL      = 3'd1;
	localparam logic [2:0] ERR_ESC_END   = 3'd2;
	localparam logic [2:0] ERR_ESC_BAD   = 3'd3;
	localparam logic [2:0] ERR_UNI_TRUNC = 3'd4;
	localparam logic [2:0] ERR_HEX_BAD   = 3'd5;
	localparam logic [2:0] ERR_UNTERM    = 3'd6;

	// source characters
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LOW_B  = 8'h62;
	localparam logic [7:0] CH_LOW_F  = 8'h66;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LOW_R  = 8'h72;
	localparam logic [7:0] CH_LOW_T  = 8'h74;
	localparam logic [7:0] CH_LOW_U  = 8'h75;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	// decoded control characters
	localparam logic [7:0] CC_BS = 8'h08;
	localparam logic [7:0] CC_FF = 8'h0C;
	localparam logic [7:0] CC_LF = 8'h0A;
	localparam logic [7:0] CC_CR = 8'h0D;
	localparam logic [7:0] CC_HT = 8'h09;

	localparam logic [20:0] CP_REPLACE = 21'h00FFFD;
	localparam logic [20:0] CP_SUPP    = 21'h010000;
	localparam logic [5:0]  SUR_HIGH   = 6'b110110;
	localparam logic [5:0]  SUR_LOW    = 6'b110111;

	typedef enum logic [3:0] {
		M_IDLE    = 4'd0,
		M_STR     = 4'd1,
		M_ESC     = 4'd2,
		M_HEX1    = 4'd3,
		M_HELD    = 4'd4,
		M_HELD_BS = 4'd5,
		M_HEX2    = 4'd6
	} mode_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] text_byte;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [7:0]  data_byte;
		logic [15:0] string_length;
		logic [2:0]  error_code;
		logic        last_of_run;
	} out_beat_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [7:0] data_byte;
		logic [2:0] error_code;
	} entry_t;

	// all results caused by one item
	typedef struct packed {
		logic [CNT_W-1:0]             n;
		entry_t [MAX_RESULTS-1:0]     entries;
		logic [15:0]                  length;
	} burst_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_t;

	typedef struct packed {
		logic [2:0]       n;
		logic [3:0][7:0]  bytes;
	} utf8_t;

	function automatic hex_t hex_value(input logic [7:0] b);
		hex_t h;
		h.ok    = 1'b1;
		h.value = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			h.value = 4'(b - 8'h30);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			h.value = 4'(b - 8'h57);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			h.value = 4'(b - 8'h37);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

	function automatic utf8_t utf8_encode(input logic [20:0] cp);
		utf8_t u;
		u.bytes = '0;
		if (cp <= 21'h7F) begin
			u.n        = 3'd1;
			u.bytes[0] = cp[7:0];
		end else if (cp <= 21'h7FF) begin
			u.n        = 3'd2;
			u.bytes[0] = {3'b110, cp[10:6]};
			u.bytes[1] = {2'b10, cp[5:0]};
		end else if (cp <= 21'hFFFF) begin
			u.n        = 3'd3;
			u.bytes[0] = {4'b1110, cp[15:12]};
			u.bytes[1] = {2'b10, cp[11:6]};
			u.bytes[2] = {2'b10, cp[5:0]};
		end else begin
			u.n        = 3'd4;
			u.bytes[0] = {5'b11110, cp[20:18]};
			u.bytes[1] = {2'b10, cp[17:12]};
			u.bytes[2] = {2'b10, cp[11:6]};
			u.bytes[3] = {2'b10, cp[5:0]};
		end
		return u;
	endfunction

endpackage

// ===== rtl/json_string_unescape_utf8.sv =====
// json string unescape to utf-8: input register, decode step and result register
//
// Source beats come in on item (kind, text_byte) under item_valid/item_ready;
// decoded results leave on result under result_valid/result_ready.
// A begin beat opens a string, byte beats carry the source text after the
// opening quote, an end beat marks the end of the text.
// Each source beat yields zero to six results: utf-8 data bytes, then at most
// one close result with the saturated decoded length or one error, with
// last_of_run set on the final result of that beat.
// A beat accepted into the input register is decoded into the result register
// once that register can take it, and its results then leave from there.
// Throughput: one source beat per cycle while each beat yields at most one
// result and the receiver keeps up; a beat with more results holds the result
// register until all are taken, since the output port moves one result per cycle.
// Reset clears the decode state to idle and empties both registers.
// When the receiver stalls, the result register holds its burst and the
// input register holds one further beat, then item_ready drops.
module json_string_unescape_utf8 #(
	parameter int LENGTH_BITS = jsu_pkg::LENGTH_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  jsu_pkg::in_beat_t  item,
	output logic               result_valid,
	input  logic               result_ready,
	output jsu_pkg::out_beat_t result
);
	import jsu_pkg::*;

	logic     valid_s1;
	in_beat_t beat_s1;
	logic     load_ok;
	logic     fire;
	burst_t   burst;

	assign fire       = valid_s1 && load_ok;
	assign item_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			beat_s1 <= item;
		end
	end

	jsu_decode #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_decode (
		.clk   (clk),
		.arst_n(arst_n),
		.beat  (beat_s1),
		.fire  (fire),
		.burst (burst)
	);

	jsu_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.burst       (burst),
		.fire        (fire),
		.load_ok     (load_ok),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

endmodule

// ===== rtl/jsu_decode.sv =====
// decode state and the combinational step that turns one source beat into a burst
module jsu_decode #(
	parameter int LENGTH_BITS = jsu_pkg::LENGTH_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  jsu_pkg::in_beat_t beat,
	input  logic              fire,
	output jsu_pkg::burst_t   burst
);
	import jsu_pkg::*;

	typedef enum logic [2:0] {
		T_NONE,
		T_BYTE,
		T_CP,
		T_CLOSE,
		T_ERR
	} tail_t;

	localparam logic [LENGTH_BITS-1:0] CNT_MAX = '1;

	mode_t                  mode_q, mode_d;
	logic [15:0]            acc_q, acc_d;
	logic [1:0]             cnt_q, cnt_d;
	logic [9:0]             held_q, held_d;
	logic [LENGTH_BITS-1:0] count_q, count_d;

	logic                   prefix;
	tail_t                  tail;
	logic [20:0]            tail_cp;
	logic [7:0]             tail_byte;
	logic [2:0]             tail_err;
	logic                   clear;
	logic                   do_plain, do_esc, do_first;
	logic [15:0]            first_v;
	hex_t                   hv;
	logic [15:0]            acc_shift;
	utf8_t                  enc;
	logic [2:0]             tail_n;
	entry_t [3:0]           tail_e;
	logic [2:0]             add_n;
	logic [LENGTH_BITS:0]   sum;
	logic [LENGTH_BITS-1:0] count_sat;
	logic [31:0]            len32;

	always_comb begin
		mode_d    = mode_q;
		acc_d     = acc_q;
		cnt_d     = cnt_q;
		held_d    = held_q;
		prefix    = 1'b0;
		tail      = T_NONE;
		tail_cp   = '0;
		tail_byte = '0;
		tail_err  = ERR_NONE;
		clear     = 1'b0;
		do_plain  = 1'b0;
		do_esc    = 1'b0;
		do_first  = 1'b0;
		first_v   = '0;
		hv        = hex_value(beat.text_byte);
		acc_shift = {acc_q[11:0], hv.value};

		case (beat.kind)
			IK_BEGIN: begin
				clear = 1'b1;
			end
			IK_BYTE: begin
				unique case (mode_q)
					M_STR: begin
						do_plain = 1'b1;
					end
					M_ESC: begin
						do_esc = 1'b1;
					end
					M_HEX1: begin
						if (!hv.ok) begin
							tail     = T_ERR;
							tail_err = ERR_HEX_BAD;
							clear    = 1'b1;
						end else begin
							acc_d = acc_shift;
							if (cnt_q == 2'd3) begin
								do_first = 1'b1;
								first_v  = acc_shift;
							end else begin
								cnt_d = cnt_q + 2'd1;
							end
						end
					end
					M_HELD: begin
						if (beat.text_byte == CH_BSLASH) begin
							mode_d = M_HELD_BS;
						end else begin
							prefix   = 1'b1;
							do_plain = 1'b1;
						end
					end
					M_HELD_BS: begin
						if (beat.text_byte == CH_LOW_U) begin
							mode_d = M_HEX2;
							acc_d  = '0;
							cnt_d  = '0;
						end else begin
							prefix = 1'b1;
							do_esc = 1'b1;
						end
					end
					M_HEX2: begin
						if (!hv.ok) begin
							prefix   = 1'b1;
							tail     = T_ERR;
							tail_err = ERR_HEX_BAD;
							clear    = 1'b1;
						end else begin
							acc_d = acc_shift;
							if (cnt_q == 2'd3) begin
								if (acc_shift[15:10] == SUR_LOW) begin
									// valid pair, one supplementary code point
									tail    = T_CP;
									tail_cp = CP_SUPP + {1'b0, held_q, acc_shift[9:0]};
									mode_d  = M_STR;
									acc_d   = '0;
									cnt_d   = '0;
									held_d  = '0;
								end else begin
									prefix   = 1'b1;
									held_d   = '0;
									do_first = 1'b1;
									first_v  = acc_shift;
								end
							end else begin
								cnt_d = cnt_q + 2'd1;
							end
						end
					end
					default: begin
					end
				endcase
			end
			IK_END: begin
				unique case (mode_q)
					M_STR: begin
						tail = T_ERR; tail_err = ERR_UNTERM; clear = 1'b1;
					end
					M_ESC: begin
						tail = T_ERR; tail_err = ERR_ESC_END; clear = 1'b1;
					end
					M_HEX1: begin
						tail = T_ERR; tail_err = ERR_UNI_TRUNC; clear = 1'b1;
					end
					M_HELD: begin
						prefix = 1'b1;
						tail = T_ERR; tail_err = ERR_UNTERM; clear = 1'b1;
					end
					M_HELD_BS: begin
						prefix = 1'b1;
						tail = T_ERR; tail_err = ERR_ESC_END; clear = 1'b1;
					end
					M_HEX2: begin
						prefix = 1'b1;
						tail = T_ERR; tail_err = ERR_UNI_TRUNC; clear = 1'b1;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase

		if (do_plain) begin
			mode_d = M_STR;
			if (beat.text_byte == CH_QUOTE) begin
				tail  = T_CLOSE;
				clear = 1'b1;
			end else if (beat.text_byte == CH_BSLASH) begin
				mode_d = M_ESC;
			end else if (beat.text_byte < CH_SPACE) begin
				tail     = T_ERR;
				tail_err = ERR_CTRL;
				clear    = 1'b1;
			end else begin
				tail      = T_BYTE;
				tail_byte = beat.text_byte;
			end
		end

		if (do_esc) begin
			mode_d = M_STR;
			tail   = T_BYTE;
			case (beat.text_byte)
				CH_QUOTE:  tail_byte = CH_QUOTE;
				CH_BSLASH: tail_byte = CH_BSLASH;
				CH_SLASH:  tail_byte = CH_SLASH;
				CH_LOW_B:  tail_byte = CC_BS;
				CH_LOW_F:  tail_byte = CC_FF;
				CH_LOW_N:  tail_byte = CC_LF;
				CH_LOW_R:  tail_byte = CC_CR;
				CH_LOW_T:  tail_byte = CC_HT;
				CH_LOW_U: begin
					tail   = T_NONE;
					mode_d = M_HEX1;
					acc_d  = '0;
					cnt_d  = '0;
				end
				default: begin
					tail     = T_ERR;
					tail_err = ERR_ESC_BAD;
					clear    = 1'b1;
				end
			endcase
		end

		if (do_first) begin
			acc_d = '0;
			cnt_d = '0;
			if (first_v[15:10] == SUR_HIGH) begin
				held_d = first_v[9:0];
				mode_d = M_HELD;
			end else begin
				mode_d  = M_STR;
				tail    = T_CP;
				tail_cp = (first_v[15:10] == SUR_LOW) ? CP_REPLACE : {5'd0, first_v};
			end
		end

		if (clear) begin
			acc_d  = '0;
			cnt_d  = '0;
			held_d = '0;
			mode_d = (beat.kind == IK_BEGIN) ? M_STR : M_IDLE;
		end
	end

	// tail results after the optional replacement character
	always_comb begin
		enc    = utf8_encode(tail_cp);
		tail_e = '0;
		tail_n = '0;
		case (tail)
			T_BYTE: begin
				tail_n              = 3'd1;
				tail_e[0].data_byte = tail_byte;
			end
			T_CP: begin
				tail_n = enc.n;
				for (int i = 0; i < 4; i++) begin
					tail_e[i].data_byte = enc.bytes[i];
				end
			end
			T_CLOSE: begin
				tail_n                = 3'd1;
				tail_e[0].result_kind = RK_CLOSE;
			end
			T_ERR: begin
				tail_n                = 3'd1;
				tail_e[0].result_kind = RK_ERROR;
				tail_e[0].error_code  = tail_err;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		add_n = (prefix ? 3'd3 : 3'd0)
			+ ((tail == T_BYTE || tail == T_CP) ? tail_n : 3'd0);
		sum       = {1'b0, count_q} + (LENGTH_BITS + 1)'(add_n);
		count_sat = sum[LENGTH_BITS] ? CNT_MAX : sum[LENGTH_BITS-1:0];
		count_d   = clear ? '0 : count_sat;
		len32     = 32'(count_sat);

		burst.n       = CNT_W'(add_n) + ((tail == T_CLOSE || tail == T_ERR) ? CNT_W'(1) : '0);
		burst.length  = (len32 > 32'h0000FFFF) ? 16'hFFFF : len32[15:0];
		burst.entries = '0;
		if (prefix) begin
			// replacement character ef bf bd, then the tail
			burst.entries[0].data_byte = 8'hEF;
			burst.entries[1].data_byte = 8'hBF;
			burst.entries[2].data_byte = 8'hBD;
			burst.entries[3]           = tail_e[0];
			burst.entries[4]           = tail_e[1];
			burst.entries[5]           = tail_e[2];
		end else begin
			burst.entries[0] = tail_e[0];
			burst.entries[1] = tail_e[1];
			burst.entries[2] = tail_e[2];
			burst.entries[3] = tail_e[3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			acc_q   <= '0;
			cnt_q   <= '0;
			held_q  <= '0;
			count_q <= '0;
		end else if (fire) begin
			mode_q  <= mode_d;
			acc_q   <= acc_d;
			cnt_q   <= cnt_d;
			held_q  <= held_d;
			count_q <= count_d;
		end
	end

endmodule

// ===== rtl/jsu_emit.sv =====
// result register holding one burst and handing it out one beat at a time
module jsu_emit (
	input  logic               clk,
	input  logic               arst_n,
	input  jsu_pkg::burst_t    burst,
	input  logic               fire,
	output logic               load_ok,
	output logic               result_valid,
	input  logic               result_ready,
	output jsu_pkg::out_beat_t result
);
	import jsu_pkg::*;

	burst_t           burst_q;
	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	entry_t           cur;
	logic             last;

	assign cur  = burst_q.entries[idx_q];
	assign last = (CNT_W'(idx_q) == burst_q.n - CNT_W'(1));

	assign result_valid = busy_q;
	assign load_ok      = !busy_q || (result_ready && last);

	always_comb begin
		result.result_kind   = cur.result_kind;
		result.data_byte     = cur.data_byte;
		result.error_code    = cur.error_code;
		result.string_length = (cur.result_kind == RK_CLOSE) ? burst_q.length : 16'd0;
		result.last_of_run   = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (fire) begin
			// an item with no results leaves the register empty
			busy_q <= (burst.n != '0);
			idx_q  <= '0;
		end else if (busy_q && result_ready) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			burst_q <= burst;
		end
	end

endmodule
